>>> src/kdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kdc_pkg
// Shared types, constants and helpers for the keyword detection confirmer.
// ---------------------------------------------------------------------------
package kdc_pkg;

  localparam int unsigned Labels     = 4;
  localparam int unsigned ScoreW     = 16;
  localparam int unsigned LabelW     = 2;
  localparam int unsigned CountW     = 4;
  localparam int unsigned SumW       = 20;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned ScoredLabs = (Labels > 4) ? 4 : Labels;

  localparam logic [CfgIdxW-1:0] CfgTrigThr  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgAvgThr   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgVerifyWn = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMinMatch = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxMatch = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLockMs   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgOnLabel  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgOffLabel = 3'd7;

  localparam logic [1:0] ModeCodeIdle   = 2'd0;
  localparam logic [1:0] ModeCodeVerify = 2'd1;
  localparam logic [1:0] ModeCodeLocked = 2'd2;

  localparam logic [1:0] IndWhite = 2'd0;
  localparam logic [1:0] IndGreen = 2'd1;
  localparam logic [1:0] IndBlue  = 2'd2;

  localparam logic OpWindow = 1'b0;
  localparam logic OpTick   = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_VERIFY = 3'b010,
    MODE_LOCKED = 3'b100
  } mode_e;

  typedef struct packed {
    logic [ScoreW-1:0] trig_thr;
    logic [ScoreW-1:0] avg_thr;
    logic [CountW-1:0] verify_wn;
    logic [CountW-1:0] min_match;
    logic [CountW-1:0] max_match;
    logic [ScoreW-1:0] lock_ms;
    logic [LabelW-1:0] on_label;
    logic [LabelW-1:0] off_label;
  } cfg_t;

  // Classified transaction between front and back
  typedef struct packed {
    logic              is_tick;
    logic [LabelW-1:0] top_label;
    logic [ScoreW-1:0] top_score;
    logic              top_valid;
  } cls_t;

  typedef struct packed {
    logic [1:0]        mode_now;
    logic [1:0]        indicator;
    logic [LabelW-1:0] top_label;
    logic [ScoreW-1:0] top_score;
    logic              top_valid;
    logic              verify_done;
    logic              verify_pass;
  } res_t;

  function automatic logic [1:0] mode_code(input mode_e m);
    logic [1:0] c;
    c = ModeCodeIdle;
    unique case (m)
      MODE_IDLE:   c = ModeCodeIdle;
      MODE_VERIFY: c = ModeCodeVerify;
      MODE_LOCKED: c = ModeCodeLocked;
      default:     c = ModeCodeIdle;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/kdc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kdc_front
// Accepts input transactions, picks the top label and registers the result.
// ---------------------------------------------------------------------------
module kdc_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          push,
  output logic                         full,
  input  wire                          op_i,
  input  wire  [kdc_pkg::ScoreW-1:0]   score_zero_i,
  input  wire  [kdc_pkg::ScoreW-1:0]   score_one_i,
  input  wire  [kdc_pkg::ScoreW-1:0]   score_two_i,
  input  wire  [kdc_pkg::ScoreW-1:0]   score_three_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output kdc_pkg::cls_t                out_data_o
);

  logic                      valid_q, valid_d;
  kdc_pkg::cls_t             data_q;
  kdc_pkg::cls_t             cls;
  logic [kdc_pkg::ScoreW-1:0] scores [4];
  logic                      accept;

  assign scores[0] = score_zero_i;
  assign scores[1] = score_one_i;
  assign scores[2] = score_two_i;
  assign scores[3] = score_three_i;

  // strict greater-than keeps the earliest label on ties
  always_comb begin
    cls           = '0;
    cls.is_tick   = (op_i == kdc_pkg::OpTick);
    if (op_i == kdc_pkg::OpWindow) begin
      for (int i = 0; i < kdc_pkg::ScoredLabs; i++) begin
        if (scores[i] > cls.top_score) begin
          cls.top_score = scores[i];
          cls.top_label = kdc_pkg::LabelW'(i);
          cls.top_valid = 1'b1;
        end
      end
    end
  end

  assign full   = valid_q && !out_ready_i;
  assign accept = push && !full;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= cls;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

>>> src/kdc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kdc_queue
// Two-entry queue of classified transactions between front and back.
// ---------------------------------------------------------------------------
module kdc_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            wr_valid_i,
  output logic           wr_ready_o,
  input  kdc_pkg::cls_t  wr_data_i,
  output logic           rd_valid_o,
  input  wire            rd_ready_i,
  output kdc_pkg::cls_t  rd_data_o
);

  kdc_pkg::cls_t mem_q [2];
  logic [1:0]    cnt_q, cnt_d;
  logic          wr_ptr_q, rd_ptr_q;
  logic          do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_ready_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule
`default_nettype wire

>>> src/kdc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kdc_back
// Verification state machine, lock timer and two-entry result queue.
// ---------------------------------------------------------------------------
module kdc_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  kdc_pkg::cfg_t        cfg_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  kdc_pkg::cls_t        in_data_i,
  output logic                 empty,
  input  wire                  pop,
  output kdc_pkg::res_t        res_o
);

  kdc_pkg::mode_e              mode_q, mode_d;
  logic [kdc_pkg::LabelW-1:0]  target_q, target_d;
  logic [kdc_pkg::CountW-1:0]  seen_q, seen_d;
  logic [kdc_pkg::CountW-1:0]  match_q, match_d;
  logic [kdc_pkg::SumW-1:0]    sum_q, sum_d;
  logic [kdc_pkg::ScoreW-1:0]  timer_q, timer_d;
  logic [kdc_pkg::SumW-1:0]    avg_prod;
  logic                        is_match, take;
  kdc_pkg::res_t               res;

  kdc_pkg::res_t               rbuf_q [2];
  logic [1:0]                  rcnt_q, rcnt_d;
  logic                        rwr_q, rrd_q, do_pop;

  assign in_ready_o = (rcnt_q != 2'd2);
  assign take       = in_valid_i && in_ready_o;
  assign is_match   = in_data_i.top_valid && (in_data_i.top_label == target_q);
  assign match_d    = is_match ? match_q + 4'd1 : match_q;
  assign avg_prod   = kdc_pkg::SumW'(cfg_i.avg_thr) * kdc_pkg::SumW'(match_d);

  always_comb begin
    mode_d           = mode_q;
    target_d         = target_q;
    seen_d           = seen_q;
    sum_d            = sum_q;
    timer_d          = timer_q;
    res              = '0;
    res.top_label    = in_data_i.top_label;
    res.top_score    = in_data_i.top_score;
    res.top_valid    = in_data_i.top_valid;
    if (in_data_i.is_tick) begin
      if (timer_q != '1) begin
        timer_d = timer_q + 16'd1;
      end
    end else begin
      unique case (mode_q)
        kdc_pkg::MODE_IDLE: begin
          if (in_data_i.top_valid && (in_data_i.top_score > cfg_i.trig_thr) &&
              ((in_data_i.top_label == cfg_i.on_label) ||
               (in_data_i.top_label == cfg_i.off_label))) begin
            mode_d   = kdc_pkg::MODE_VERIFY;
            target_d = in_data_i.top_label;
            seen_d   = '0;
            sum_d    = '0;
          end
        end
        kdc_pkg::MODE_VERIFY: begin
          seen_d = seen_q + 4'd1;
          if (is_match) begin
            sum_d = sum_q + kdc_pkg::SumW'(in_data_i.top_score);
          end
          if (seen_d >= cfg_i.verify_wn) begin
            res.verify_done = 1'b1;
            if ((match_d != '0) && (match_d >= cfg_i.min_match) &&
                (match_d <= cfg_i.max_match) && (sum_d > avg_prod)) begin
              res.verify_pass = 1'b1;
              mode_d          = kdc_pkg::MODE_LOCKED;
              timer_d         = '0;
            end else begin
              mode_d = kdc_pkg::MODE_IDLE;
            end
          end
        end
        kdc_pkg::MODE_LOCKED: begin
          if (timer_q > cfg_i.lock_ms) begin
            mode_d = kdc_pkg::MODE_IDLE;
          end
        end
        default: mode_d = kdc_pkg::MODE_IDLE;
      endcase
    end
    res.mode_now = kdc_pkg::mode_code(mode_d);
    if (mode_d == kdc_pkg::MODE_LOCKED) begin
      res.indicator = (target_d == cfg_i.on_label) ? kdc_pkg::IndGreen : kdc_pkg::IndBlue;
    end else begin
      res.indicator = kdc_pkg::IndWhite;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= kdc_pkg::MODE_IDLE;
      target_q <= '0;
      seen_q   <= '0;
      match_q  <= '0;
      sum_q    <= '0;
      timer_q  <= '0;
    end else if (take) begin
      mode_q   <= mode_d;
      target_q <= target_d;
      seen_q   <= seen_d;
      timer_q  <= timer_d;
      if (!in_data_i.is_tick && (mode_q == kdc_pkg::MODE_VERIFY)) begin
        match_q <= match_d;
        sum_q   <= sum_d;
      end else if (!in_data_i.is_tick && (mode_d == kdc_pkg::MODE_VERIFY)) begin
        match_q <= '0;
        sum_q   <= '0;
      end
    end
  end

  // result queue
  assign empty  = (rcnt_q == 2'd0);
  assign do_pop = pop && !empty;
  assign res_o  = rbuf_q[rrd_q];

  always_comb begin
    rcnt_d = rcnt_q;
    if (take && !do_pop) begin
      rcnt_d = rcnt_q + 2'd1;
    end else if (!take && do_pop) begin
      rcnt_d = rcnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= 2'd0;
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
    end else begin
      rcnt_q <= rcnt_d;
      if (take) begin
        rwr_q <= ~rwr_q;
      end
      if (do_pop) begin
        rrd_q <= ~rrd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rbuf_q[rwr_q] <= res;
    end
  end

endmodule
`default_nettype wire

>>> src/keyword_detection_confirmer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// keyword_detection_confirmer
// Confirms on/off keyword detections over a run of classifier windows.
// ---------------------------------------------------------------------------
// Takes one transaction (a scored window or a millisecond tick) per clock
// while full is low and returns exactly one result per transaction, in
// order. The front stage picks the top label and hands it through a
// two-entry queue to the back stage, which runs the verify/lock state
// machine and holds results in a two-entry queue; a result is registered
// in the front stage, the queue and the result queue before it is ready.
// Configuration writes should only happen while no transaction is in flight.
module keyword_detection_confirmer (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [kdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [kdc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire                          push,
  output logic                         full,
  input  wire                          op_i,
  input  wire  [kdc_pkg::ScoreW-1:0]   score_zero_i,
  input  wire  [kdc_pkg::ScoreW-1:0]   score_one_i,
  input  wire  [kdc_pkg::ScoreW-1:0]   score_two_i,
  input  wire  [kdc_pkg::ScoreW-1:0]   score_three_i,
  output logic                         empty,
  input  wire                          pop,
  output logic [1:0]                   mode_now_o,
  output logic [1:0]                   indicator_o,
  output logic [kdc_pkg::LabelW-1:0]   top_label_o,
  output logic [kdc_pkg::ScoreW-1:0]   top_score_o,
  output logic                         top_valid_o,
  output logic                         verify_done_o,
  output logic                         verify_pass_o
);

  kdc_pkg::cfg_t cfg_q;
  kdc_pkg::cls_t f2q_data, q2b_data;
  kdc_pkg::res_t res;
  logic          f2q_valid, f2q_ready, q2b_valid, q2b_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trig_thr  <= 16'd58982;
      cfg_q.avg_thr   <= 16'd58982;
      cfg_q.verify_wn <= 4'd10;
      cfg_q.min_match <= 4'd4;
      cfg_q.max_match <= 4'd6;
      cfg_q.lock_ms   <= 16'd3000;
      cfg_q.on_label  <= 2'd0;
      cfg_q.off_label <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kdc_pkg::CfgTrigThr:  cfg_q.trig_thr  <= cfg_wdata_i;
        kdc_pkg::CfgAvgThr:   cfg_q.avg_thr   <= cfg_wdata_i;
        kdc_pkg::CfgVerifyWn: cfg_q.verify_wn <= cfg_wdata_i[kdc_pkg::CountW-1:0];
        kdc_pkg::CfgMinMatch: cfg_q.min_match <= cfg_wdata_i[kdc_pkg::CountW-1:0];
        kdc_pkg::CfgMaxMatch: cfg_q.max_match <= cfg_wdata_i[kdc_pkg::CountW-1:0];
        kdc_pkg::CfgLockMs:   cfg_q.lock_ms   <= cfg_wdata_i;
        kdc_pkg::CfgOnLabel:  cfg_q.on_label  <= cfg_wdata_i[kdc_pkg::LabelW-1:0];
        kdc_pkg::CfgOffLabel: cfg_q.off_label <= cfg_wdata_i[kdc_pkg::LabelW-1:0];
        default: ;
      endcase
    end
  end

  kdc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .score_zero_i  (score_zero_i),
    .score_one_i   (score_one_i),
    .score_two_i   (score_two_i),
    .score_three_i (score_three_i),
    .out_valid_o   (f2q_valid),
    .out_ready_i   (f2q_ready),
    .out_data_o    (f2q_data)
  );

  kdc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f2q_valid),
    .wr_ready_o (f2q_ready),
    .wr_data_i  (f2q_data),
    .rd_valid_o (q2b_valid),
    .rd_ready_i (q2b_ready),
    .rd_data_o  (q2b_data)
  );

  kdc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (q2b_valid),
    .in_ready_o (q2b_ready),
    .in_data_i  (q2b_data),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res)
  );

  assign mode_now_o    = res.mode_now;
  assign indicator_o   = res.indicator;
  assign top_label_o   = res.top_label;
  assign top_score_o   = res.top_score;
  assign top_valid_o   = res.top_valid;
  assign verify_done_o = res.verify_done;
  assign verify_pass_o = res.verify_pass;

endmodule
`default_nettype wire
